// ----- hdl/isl_pkg.sv -----
// Package for the indexed shift list: sizes, command and status codes,
// transaction payload structs and the per-cell control struct.
// No dependencies.
package isl_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 5;
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int VAL_W = 32;

    typedef logic signed [VAL_W-1:0] t_value;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_READ   = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_FIND   = 3'd4,
        CMD_REMOVE = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // what a cell does on the next edge
    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_LOAD      = 2'd1,
        CELL_TAKE_LOW  = 2'd2,
        CELL_TAKE_HIGH = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctrl;

    typedef struct packed {
        logic [2:0]       command;
        logic [POS_W-1:0] position;
        t_value           item_value;
    } t_in_item;

    typedef struct packed {
        t_value           read_value;
        logic [IDX_W-1:0] found_position;
        logic [1:0]       status;
        logic [CNT_W-1:0] element_total;
    } t_out_item;

endpackage

// ----- hdl/isl_cell.sv -----
// One storage cell of the list: holds a value, loads a new one or takes
// a neighbor's value, and compares its content against the search key.
// Depends on isl_pkg.
module isl_cell
    import isl_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_value     i_item,
    input  t_value     i_low,
    input  t_value     i_high,
    input  t_value     i_key,
    output t_value     o_value,
    output logic       o_match
);

    t_value r_value;
    t_value n_value;

    always_comb begin
        case (i_ctrl.op)
            CELL_LOAD:      n_value = i_item;
            CELL_TAKE_LOW:  n_value = i_low;
            CELL_TAKE_HIGH: n_value = i_high;
            default:        n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_match = (r_value == i_key);

endmodule

// ----- hdl/indexed_shift_list.sv -----
// Indexed shift list: a row of cells holding an ordered list plus its count.
// Depends on isl_pkg and isl_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one command
//   per transaction: clear, append, read, insert, find or remove.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly
//   one result transaction per command, in order.
//   Latency: the result is valid in the cycle after the command is accepted.
//   Throughput: one command per cycle unless the receiver stalls with a
//   result pending. The row of cells shifts all entries at once and every
//   cell compares against the search key in parallel, so nothing iterates.
//   A single output register separates the channels: a new command is taken
//   while the previous result is being taken in the same cycle; while the
//   receiver stalls with a result pending, o_in_stall is raised.
//   Reset (i_rst_n low, synchronous) empties the list and drops any pending
//   result; cell contents are left as they are and are never visible since
//   only entries below the count are read or searched.
module indexed_shift_list
    import isl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic             w_accept;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_item        r_out_data;
    t_out_item        n_out_data;

    t_cell_ctrl       w_ctrl  [DEPTH];
    t_value           w_value [DEPTH];
    logic [DEPTH-1:0] w_match;
    logic [DEPTH-1:0] w_hit;
    logic [DEPTH-1:0] w_first;
    logic             w_full;
    logic             w_pos_lt;
    logic             w_pos_le;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_pos_lt = (CMP_W'(i_in_data.position) <  CMP_W'(r_count));
    assign w_pos_le = (CMP_W'(i_in_data.position) <= CMP_W'(r_count));

    // lowest hit among valid entries
    assign w_first = w_hit & (~w_hit + DEPTH'(1));

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_value w_low;
            t_value w_high;
            if (g == 0) begin : g_bottom
                assign w_low = w_value[g];
            end else begin : g_mid_low
                assign w_low = w_value[g-1];
            end
            if (g == DEPTH - 1) begin : g_top
                assign w_high = w_value[g];
            end else begin : g_mid_high
                assign w_high = w_value[g+1];
            end

            isl_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl[g]),
                .i_item  (i_in_data.item_value),
                .i_low   (w_low),
                .i_high  (w_high),
                .i_key   (i_in_data.item_value),
                .o_value (w_value[g]),
                .o_match (w_match[g])
            );

            assign w_hit[g] = w_match[g] & (CMP_W'(g) < CMP_W'(r_count));
        end
    endgenerate

    // cell control and result
    always_comb begin
        logic [IDX_W-1:0] v_fp;
        t_cmd             v_cmd;

        v_cmd   = t_cmd'(i_in_data.command);
        n_count = r_count;
        v_fp    = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_ctrl[i].op = CELL_HOLD;
            if (w_first[i]) begin
                v_fp = v_fp | IDX_W'(i);
            end
        end

        n_out_data.read_value     = '0;
        n_out_data.found_position = '0;
        n_out_data.status         = ST_OK;

        case (v_cmd)
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_APPEND: begin
                if (w_full) begin
                    n_out_data.status = ST_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CMP_W'(i) == CMP_W'(r_count)) begin
                            w_ctrl[i].op = CELL_LOAD;
                        end
                    end
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (!w_pos_lt) begin
                    n_out_data.status = ST_RANGE;
                end else begin
                    n_out_data.read_value = w_value[i_in_data.position[IDX_W-1:0]];
                end
            end
            CMD_INSERT: begin
                if (!w_pos_le) begin
                    n_out_data.status = ST_RANGE;
                end else if (w_full) begin
                    n_out_data.status = ST_FULL;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CMP_W'(i) > CMP_W'(i_in_data.position)) begin
                            w_ctrl[i].op = CELL_TAKE_LOW;
                        end else if (CMP_W'(i) == CMP_W'(i_in_data.position)) begin
                            w_ctrl[i].op = CELL_LOAD;
                        end
                    end
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_FIND: begin
                if (w_hit == '0) begin
                    n_out_data.status = ST_NOTFOUND;
                end else begin
                    n_out_data.found_position = v_fp;
                end
            end
            CMD_REMOVE: begin
                if (!w_pos_lt) begin
                    n_out_data.status = ST_RANGE;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CMP_W'(i) >= CMP_W'(i_in_data.position)) begin
                            w_ctrl[i].op = CELL_TAKE_HIGH;
                        end
                    end
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase

        n_out_data.element_total = n_count;

        if (!w_accept) begin
            n_count = r_count;
            for (int i = 0; i < DEPTH; i++) begin
                w_ctrl[i].op = CELL_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- bench/isl_checker.sv -----
// Checker for the indexed shift list: watches both channels, predicts each result
// from its own copy of the list and compares field by field.
// Depends on isl_pkg.
module isl_checker
    import isl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_list_size,
    output int        o_checked,
    output int        o_flagged
);

    t_value    list_cells [DEPTH];
    int        list_fill;
    t_out_item expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_list_size  = 0;
        o_checked    = 0;
        o_flagged    = 0;
        list_fill    = 0;
    end

    // Applies one command to the shadow list and returns the result it should give.
    task automatic apply_command(input t_in_item cmd, output t_out_item res);
        int p;
        int n;
        p = int'(cmd.position);
        n = list_fill;
        res = '0;
        res.status = ST_OK;
        case (cmd.command)
            CMD_CLEAR: begin
                n = 0;
            end
            CMD_APPEND: begin
                if (n >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_cells[n] = cmd.item_value;
                    n++;
                end
            end
            CMD_READ: begin
                if (p >= n) begin
                    res.status = ST_RANGE;
                end else begin
                    res.read_value = list_cells[p];
                end
            end
            CMD_INSERT: begin
                // range check wins over the full check
                if (p > n) begin
                    res.status = ST_RANGE;
                end else if (n >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = n; i > p; i--) list_cells[i] = list_cells[i-1];
                    list_cells[p] = cmd.item_value;
                    n++;
                end
            end
            CMD_FIND: begin
                res.status = ST_NOTFOUND;
                for (int i = 0; i < n; i++) begin
                    if (list_cells[i] == cmd.item_value) begin
                        res.found_position = i[IDX_W-1:0];
                        res.status = ST_OK;
                        break;
                    end
                end
            end
            CMD_REMOVE: begin
                if (p >= n) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = p; i + 1 < n; i++) list_cells[i] = list_cells[i+1];
                    n--;
                end
            end
            default: begin
            end
        endcase
        list_fill = n;
        res.element_total = n[CNT_W-1:0];
    endtask

    task automatic report_miss(input string what, input t_out_item want, input t_out_item got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("[%0t] %s: expected rd=%h fp=%0d st=%0d n=%0d, got rd=%h fp=%0d st=%0d n=%0d",
                     $time, what, want.read_value, want.found_position, want.status,
                     want.element_total, got.read_value, got.found_position, got.status,
                     got.element_total);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            expected_results.delete();
            list_fill = 0;
        end else begin
            // the result taken at this edge belongs to an older command, so check first
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (expected_results.size() == 0) begin
                    report_miss("unexpected result", '0, i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.read_value !== want.read_value ||
                        i_out_data.found_position !== want.found_position ||
                        i_out_data.status !== want.status ||
                        i_out_data.element_total !== want.element_total)
                        report_miss("result mismatch", want, i_out_data);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_command(i_in_data, want);
                if (want.status != ST_OK) o_flagged++;
                expected_results.push_back(want);
            end
        end
        o_pending   = expected_results.size();
        o_list_size = list_fill;
    end

endmodule

// ----- bench/tb_indexed_shift_list.sv -----
// Testbench top for the indexed shift list: clock, reset, command stimulus and
// a randomly stalling receiver. Depends on isl_pkg, indexed_shift_list, isl_checker.
module tb_indexed_shift_list;
    import isl_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS = 500;
    localparam int BURST_ITEMS  = 30;
    localparam int LONG_HOLD    = 60;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int     fail_count;
    int     pending;
    int     list_size;
    int     checked;
    int     flagged;
    int     sent = 0;
    bit     hold_pending = 1'b0;
    bit     burst_mode = 1'b0;
    bit     growing = 1'b1;
    t_value value_pool [8];

    indexed_shift_list i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    isl_checker u_list_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_list_size (list_size),
        .o_checked   (checked),
        .o_flagged   (flagged)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Grows the list toward full, then shrinks it toward empty; a quarter of the
    // positions are drawn over the whole field to hit the range checks.
    function automatic t_in_item random_command();
        t_in_item   item;
        int         r;
        int         k;
        int         size;
        int         grow_cut [6];
        int         shrink_cut [6];
        logic [2:0] cmd_order [7];
        grow_cut   = '{30, 50, 65, 82, 95, 98};
        shrink_cut = '{8, 16, 32, 50, 95, 98};
        cmd_order  = '{CMD_APPEND, CMD_INSERT, CMD_READ, CMD_FIND, CMD_REMOVE, CMD_CLEAR,
                       CMD_SPARE_LO};
        size = list_size;
        if (size >= DEPTH) growing = 1'b0;
        else if (size == 0) growing = 1'b1;
        r = $urandom_range(0, 99);
        k = 0;
        while (k < 6 && r >= (growing ? grow_cut[k] : shrink_cut[k])) k++;
        item.command = cmd_order[k];
        if (k == 6 && $urandom_range(0, 1)) item.command = CMD_SPARE_HI;
        if ($urandom_range(0, 3) == 0)
            item.position = POS_W'($urandom_range(0, 31));
        else if (item.command == CMD_INSERT)
            item.position = POS_W'($urandom_range(0, size));
        else
            item.position = (size == 0) ? '0 : POS_W'($urandom_range(0, size - 1));
        item.item_value = $urandom_range(0, 1) ? value_pool[3'($urandom_range(0, 7))]
                                               : t_value'($urandom);
        return item;
    endfunction

    // Offers one transaction after a random gap (none in burst mode) and waits until it is taken.
    task automatic offer(input bit pick, input logic [2:0] cmd, input int pos,
                         input t_value val);
        t_in_item item;
        int       gap;
        gap = burst_mode ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        if (pick) begin
            item = random_command();
        end else begin
            item.command    = cmd;
            item.position   = pos[POS_W-1:0];
            item.item_value = val;
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // receiver: random stalls, quiet stretches, and one long hold on request
    initial begin
        int stall_left;
        bit quiet;
        stall_left = 0;
        quiet = 1'b0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 99) == 0) quiet = ~quiet;
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !quiet) begin
                stall_left = pick_gap();
            end
            out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    initial begin
        value_pool[0] = 32'sh7FFF_FFFF;
        value_pool[1] = 32'sh8000_0000;
        value_pool[2] = '0;
        value_pool[3] = 32'shFFFF_FFFF;
        for (int i = 4; i < 8; i++) value_pool[i] = t_value'($urandom);
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty list, extreme values, ends of the list, range and not-found cases
        offer(1'b0, CMD_CLEAR,  0,  '0);
        offer(1'b0, CMD_FIND,   0,  '0);
        offer(1'b0, CMD_READ,   0,  '0);
        offer(1'b0, CMD_REMOVE, 0,  '0);
        offer(1'b0, CMD_INSERT, 1,  32'sh0001_0000);
        offer(1'b0, CMD_APPEND, 0,  32'sh7FFF_FFFF);
        offer(1'b0, CMD_APPEND, 31, 32'sh8000_0000);
        offer(1'b0, CMD_INSERT, 0,  '0);
        offer(1'b0, CMD_INSERT, 3,  32'shFFFF_FFFF);
        offer(1'b0, CMD_INSERT, 5,  32'sh0002_8000);
        offer(1'b0, CMD_READ,   0,  '0);
        offer(1'b0, CMD_READ,   3,  '0);
        offer(1'b0, CMD_READ,   4,  '0);
        offer(1'b0, CMD_READ,   31, '0);
        offer(1'b0, CMD_APPEND, 0,  32'sh8000_0000);
        offer(1'b0, CMD_FIND,   0,  32'sh8000_0000);
        offer(1'b0, CMD_FIND,   0,  32'sh0000_3039);
        offer(1'b0, CMD_REMOVE, 0,  '0);
        offer(1'b0, CMD_REMOVE, 3,  '0);
        offer(1'b0, CMD_REMOVE, 16, '0);
        offer(1'b0, CMD_SPARE_LO, 7,  '0);
        offer(1'b0, CMD_SPARE_HI, 31, 32'shFFFF_FFFF);
        offer(1'b0, CMD_CLEAR,  0,  '0);
        drain();

        // output held off while commands keep coming back to back
        @(posedge clk);
        hold_pending = 1'b1;
        burst_mode = 1'b1;
        repeat (BURST_ITEMS) offer(1'b1, CMD_CLEAR, 0, '0);
        burst_mode = 1'b0;
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 24) == 0) burst_mode = ~burst_mode;
            if (n == RANDOM_ITEMS / 2) drain();
            offer(1'b1, CMD_CLEAR, 0, '0);
        end
        drain();
        repeat (4) @(negedge clk);

        $display("Sent %0d commands, checked %0d results (%0d with an error status),",
                 sent, checked, flagged);
        $display("with random gaps on both sides and one long output hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/isl_pkg.sv
hdl/isl_cell.sv
hdl/indexed_shift_list.sv
bench/isl_checker.sv
bench/tb_indexed_shift_list.sv
